/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, also checked across reset
`define ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/des_pkg.sv */
// ---------------------------------------------------------------------------
// des_pkg
// Types, constants and helpers shared by the disk elevator scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package des_pkg;

   localparam int QUEUE_CAPACITY_DEF    = 16;
   localparam int UNIT_COUNT_DEF        = 2;
   localparam int SECTORS_PER_TRACK_DEF = 16;
   localparam int MAX_TRACKS_DEF        = 1024;

   localparam int TRK_W  = 10;
   localparam int SEC_W  = 4;
   localparam int CNT_W  = 5;
   localparam int BUF_W  = 32;
   localparam int RQ_W   = 6;
   localparam int CFG_W  = 11;
   localparam int LIM_W  = 17;
   localparam int STAT_W = 3;
   localparam int SUM_W  = 7;

   localparam int MAX_BURST    = 16;
   localparam int SECTOR_SHIFT = 9;      // 512 byte sectors
   localparam logic [CFG_W-1:0] TRACKS_RESET = 11'd1024;

   localparam logic CSR_TRACKS_ZERO = 1'b0;
   localparam logic CSR_TRACKS_ONE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 3'd0,
      ST_CMD   = 3'd1,
      ST_EMPTY = 3'd2,
      ST_FULL  = 3'd3,
      ST_BAD   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      K_ENQ,
      K_DISP,
      K_BAD
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_INSERT,
      S_EMIT,
      S_RESULT
   } state_type;

   typedef struct packed {
      kind_type          kind;
      logic              unit;
      logic [TRK_W-1:0]  track;
      logic [SEC_W-1:0]  first;
      logic [CNT_W-1:0]  count;
      logic [BUF_W-1:0]  buffer;
      logic [RQ_W-1:0]   requester;
      logic              is_write;
   } cmd_type;

   // request word kept in the store; the track lives in the order list
   typedef struct packed {
      logic [SEC_W-1:0]  first;
      logic [CNT_W-1:0]  count;
      logic [BUF_W-1:0]  buffer;
      logic [RQ_W-1:0]   requester;
      logic              is_write;
   } word_type;

   localparam int WORD_W = $bits(word_type);

   typedef struct packed {
      status_type        status;
      logic              unit;
      logic [TRK_W-1:0]  track;
      logic [SEC_W-1:0]  sector;
      logic [BUF_W-1:0]  buffer;
      logic [RQ_W-1:0]   requester;
      logic              write;
      logic              last;
   } rsp_type;

   function automatic logic [LIM_W-1:0] cap_limit(input logic [CFG_W-1:0] v,
                                                 input logic [LIM_W-1:0] lim);
      logic [LIM_W-1:0] w;
      w = LIM_W'(v);
      return (w > lim) ? lim : w;
   endfunction

endpackage

`default_nettype wire

/* sv/des_ram.sv */
// ---------------------------------------------------------------------------
// des_ram
// Generic single write port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module des_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/des_front.sv */
// ---------------------------------------------------------------------------
// des_front
// Track count registers and request classification ahead of the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module des_front
   import des_pkg::*;
#(
   parameter int UNIT_COUNT        = UNIT_COUNT_DEF,
   parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF,
   parameter int MAX_TRACKS        = MAX_TRACKS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_op,
   input  wire cmd_type          req_cmd,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output cmd_type               push_cmd,
   output logic [LIM_W-1:0]      limit [2]
);

   logic [CFG_W-1:0] trk0_ff, trk1_ff;
   logic [LIM_W-1:0] sel_lim;
   logic [SUM_W-1:0] sec_end;
   logic             unit_ok, enq_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         trk0_ff <= TRACKS_RESET;
         trk1_ff <= TRACKS_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_TRACKS_ZERO) begin
            trk0_ff <= csr_data;
         end
         if (csr_index == CSR_TRACKS_ONE) begin
            trk1_ff <= csr_data;
         end
      end
   end

   assign limit[0] = cap_limit(trk0_ff, LIM_W'(MAX_TRACKS));
   assign limit[1] = cap_limit(trk1_ff, LIM_W'(MAX_TRACKS));

   always_comb begin
      sel_lim = req_cmd.unit ? limit[1] : limit[0];
      unit_ok = int'(req_cmd.unit) < UNIT_COUNT;
      sec_end = SUM_W'(req_cmd.first) + SUM_W'(req_cmd.count);
      enq_ok  = (LIM_W'(req_cmd.track) < sel_lim)
             && (SUM_W'(req_cmd.first) < SUM_W'(SECTORS_PER_TRACK))
             && (req_cmd.count != '0)
             && (req_cmd.count <= CNT_W'(MAX_BURST))
             && (sec_end <= SUM_W'(SECTORS_PER_TRACK));
      push_cmd = req_cmd;
      if (!unit_ok) begin
         push_cmd.kind = K_BAD;
      end else if (req_op) begin
         push_cmd.kind = K_DISP;
      end else if (enq_ok) begin
         push_cmd.kind = K_ENQ;
      end else begin
         push_cmd.kind = K_BAD;
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

/* sv/des_fifo.sv */
// ---------------------------------------------------------------------------
// des_fifo
// Two entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module des_fifo
   import des_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   cmd_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_cmd    = mem_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_cmd;
      end
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= ~rptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

`default_nettype wire

/* sv/des_back.sv */
// ---------------------------------------------------------------------------
// des_back
// Sweep queues, sorted insert scan, dispatch and sector command burst.
// ---------------------------------------------------------------------------
`default_nettype none

module des_back
   import des_pkg::*;
#(
   parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEF,
   parameter int UNIT_COUNT     = UNIT_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire cmd_type          in_cmd,
   input  wire logic [LIM_W-1:0] limit [2],
   output logic                  out_valid,
   input  wire logic             out_ready,
   output rsp_type               out_rsp
);

   localparam int CAP   = QUEUE_CAPACITY;
   localparam int SW    = $clog2(CAP);
   localparam int NW    = $clog2(CAP + 1);
   localparam int DEPTH = UNIT_COUNT * CAP;
   localparam int AW    = $clog2(DEPTH);

   // order list per unit: positions below the fill hold queued slots in
   // sweep order, positions from the fill upward hold the free slots
   logic [TRK_W-1:0] ord_trk_ff  [UNIT_COUNT][CAP];
   logic [TRK_W-1:0] ord_trk_in  [UNIT_COUNT][CAP];
   logic [SW-1:0]    ord_slot_ff [UNIT_COUNT][CAP];
   logic [SW-1:0]    ord_slot_in [UNIT_COUNT][CAP];
   logic [NW-1:0]    ncur_ff [UNIT_COUNT], ncur_in [UNIT_COUNT];
   logic [NW-1:0]    nnext_ff [UNIT_COUNT], nnext_in [UNIT_COUNT];
   logic [TRK_W-1:0] arm_ff [UNIT_COUNT], arm_in [UNIT_COUNT];

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [TRK_W-1:0] trk_ff, trk_in;
   logic [NW-1:0]    idx_ff, idx_in, hi_ff, hi_in, pos_ff, pos_in;
   logic             to_cur_ff, to_cur_in;
   status_type       stat_ff, stat_in;
   logic [CNT_W-1:0] sec_ff, sec_in;
   logic             valid_ff, valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             iu, cu;
   logic [NW-1:0]    ncur, nnext, used, usedm1, cused;
   logic [SW-1:0]    free_slot;
   logic             out_free, is_last;
   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   word_type         wr_word, rd_word;
   logic [WORD_W-1:0] rd_data;

   des_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_word = word_type'(rd_data);

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      trk_ff    <= trk_in;
      idx_ff    <= idx_in;
      hi_ff     <= hi_in;
      pos_ff    <= pos_in;
      to_cur_ff <= to_cur_in;
      stat_ff   <= stat_in;
      sec_ff    <= sec_in;
      rsp_ff    <= rsp_in;
      ord_trk_ff <= ord_trk_in;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         for (int u = 0; u < UNIT_COUNT; u++) begin
            ncur_ff[u]  <= '0;
            nnext_ff[u] <= '0;
            arm_ff[u]   <= '0;
            for (int p = 0; p < CAP; p++) begin
               ord_slot_ff[u][p] <= SW'(p);
            end
         end
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         ncur_ff     <= ncur_in;
         nnext_ff    <= nnext_in;
         arm_ff      <= arm_in;
         ord_slot_ff <= ord_slot_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      trk_in      = trk_ff;
      idx_in      = idx_ff;
      hi_in       = hi_ff;
      pos_in      = pos_ff;
      to_cur_in   = to_cur_ff;
      stat_in     = stat_ff;
      sec_in      = sec_ff;
      ncur_in     = ncur_ff;
      nnext_in    = nnext_ff;
      arm_in      = arm_ff;
      ord_trk_in  = ord_trk_ff;
      ord_slot_in = ord_slot_ff;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_word     = '0;

      in_ready = (state_ff == S_IDLE);
      out_free = !valid_ff || out_ready;
      valid_in = valid_ff && !out_ready;

      iu     = (UNIT_COUNT == 1) ? 1'b0 : in_cmd.unit;
      cu     = (UNIT_COUNT == 1) ? 1'b0 : cmd_ff.unit;
      ncur   = ncur_ff[iu];
      nnext  = nnext_ff[iu];
      used   = ncur + nnext;
      usedm1 = used - NW'(1);
      cused  = ncur_ff[cu] + nnext_ff[cu];
      free_slot = ord_slot_ff[cu][cused[SW-1:0]];
      rd_addr = AW'(int'(iu) * CAP + int'(ord_slot_ff[iu][0]));
      wr_addr = AW'(int'(cu) * CAP + int'(free_slot));
      is_last = (sec_ff + CNT_W'(1)) == rd_word.count;

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd_in = in_cmd;
               trk_in = in_cmd.track;
               case (in_cmd.kind)
                  K_ENQ: begin
                     if (used >= NW'(CAP)) begin
                        stat_in  = ST_FULL;
                        state_in = S_RESULT;
                     end else begin
                        to_cur_in = (ncur == '0) || (in_cmd.track > arm_ff[iu]);
                        idx_in    = to_cur_in ? '0 : ncur;
                        pos_in    = idx_in;
                        hi_in     = to_cur_in ? ncur : used;
                        state_in  = S_SCAN;
                     end
                  end
                  K_DISP: begin
                     if (used == '0) begin
                        stat_in  = ST_EMPTY;
                        state_in = S_RESULT;
                     end else begin
                        // promote the next sweep when the current one is empty
                        ncur_in[iu]  = ((ncur == '0) ? nnext : ncur) - NW'(1);
                        nnext_in[iu] = (ncur == '0) ? '0 : nnext;
                        for (int p = 0; p < CAP - 1; p++) begin
                           if (NW'(p) < usedm1) begin
                              ord_trk_in[iu][p]  = ord_trk_ff[iu][p+1];
                              ord_slot_in[iu][p] = ord_slot_ff[iu][p+1];
                           end
                        end
                        ord_trk_in[iu][usedm1[SW-1:0]]  = ord_trk_ff[iu][0];
                        ord_slot_in[iu][usedm1[SW-1:0]] = ord_slot_ff[iu][0];
                        trk_in = ord_trk_ff[iu][0];
                        rd_en  = 1'b1;
                        if (LIM_W'(ord_trk_ff[iu][0]) >= limit[in_cmd.unit]) begin
                           stat_in  = ST_BAD;
                           state_in = S_RESULT;
                        end else begin
                           arm_in[iu] = ord_trk_ff[iu][0];
                           sec_in     = '0;
                           state_in   = S_EMIT;
                        end
                     end
                  end
                  default: begin
                     stat_in  = ST_BAD;
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (idx_ff < hi_ff) begin
               if (ord_trk_ff[cu][idx_ff[SW-1:0]] <= cmd_ff.track) begin
                  pos_in = idx_ff + NW'(1);
               end
               idx_in = idx_ff + NW'(1);
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            for (int p = 1; p < CAP; p++) begin
               if ((NW'(p) > pos_ff) && (NW'(p) <= cused)) begin
                  ord_trk_in[cu][p]  = ord_trk_ff[cu][p-1];
                  ord_slot_in[cu][p] = ord_slot_ff[cu][p-1];
               end
            end
            ord_trk_in[cu][pos_ff[SW-1:0]]  = cmd_ff.track;
            ord_slot_in[cu][pos_ff[SW-1:0]] = free_slot;
            wr_en             = 1'b1;
            wr_word.first     = cmd_ff.first;
            wr_word.count     = cmd_ff.count;
            wr_word.buffer    = cmd_ff.buffer;
            wr_word.requester = cmd_ff.requester;
            wr_word.is_write  = cmd_ff.is_write;
            if (to_cur_ff) begin
               ncur_in[cu] = ncur_ff[cu] + NW'(1);
            end else begin
               nnext_in[cu] = nnext_ff[cu] + NW'(1);
            end
            stat_in  = ST_OK;
            state_in = S_RESULT;
         end
         S_EMIT: begin
            if (out_free) begin
               valid_in         = 1'b1;
               rsp_in.status    = ST_CMD;
               rsp_in.unit      = cmd_ff.unit;
               rsp_in.track     = trk_ff;
               rsp_in.sector    = rd_word.first + sec_ff[SEC_W-1:0];
               rsp_in.buffer    = rd_word.buffer + (BUF_W'(sec_ff) << SECTOR_SHIFT);
               rsp_in.requester = rd_word.requester;
               rsp_in.write     = rd_word.is_write;
               rsp_in.last      = is_last;
               sec_in           = sec_ff + CNT_W'(1);
               if (is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RESULT: begin
            if (out_free) begin
               valid_in      = 1'b1;
               rsp_in        = '0;
               rsp_in.status = stat_ff;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

/* sv/disk_elevator_scheduler.sv */
// ---------------------------------------------------------------------------
// disk_elevator_scheduler
// C-LOOK request scheduler for up to two disk units.
// ---------------------------------------------------------------------------
// The front classifies each request against the track count registers and
// places it in a two entry queue; the back runs it against per unit sorted
// current and next sweep lists and a request store RAM. An enqueue scans the
// sweep it is sorted into, one list entry compared per cycle, and then inserts
// the request. A dispatch emits its sector commands through the single
// output register, which back-pressure on the output can stall; status only
// results also pass through it. One item is worked on at a time in the back.
`default_nettype none

`include "assert_macros.svh"

module disk_elevator_scheduler
   import des_pkg::*;
#(
   parameter int QUEUE_CAPACITY    = QUEUE_CAPACITY_DEF,
   parameter int UNIT_COUNT        = UNIT_COUNT_DEF,
   parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF,
   parameter int MAX_TRACKS        = MAX_TRACKS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_data,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // disk_unit, track, first_sector, sector_count, buffer_address, requester,
   // is_write, zero fill
   input  wire logic [63:0]      req_tdata,
   // operation
   input  wire logic             req_tuser,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // out_unit, out_track, out_sector, out_buffer, out_requester, out_write,
   // zero fill
   output logic [55:0]           rsp_tdata,
   // status
   output logic [STAT_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   cmd_type          req_cmd, push_cmd, pop_cmd;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   logic [LIM_W-1:0] limit [2];
   rsp_type          rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      req_cmd           = '0;
      req_cmd.kind      = K_BAD;
      req_cmd.unit      = req_tdata[0];
      req_cmd.track     = req_tdata[10:1];
      req_cmd.first     = req_tdata[14:11];
      req_cmd.count     = req_tdata[19:15];
      req_cmd.buffer    = req_tdata[51:20];
      req_cmd.requester = req_tdata[57:52];
      req_cmd.is_write  = req_tdata[58];
   end

   des_front #(
      .UNIT_COUNT        (UNIT_COUNT),
      .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
      .MAX_TRACKS        (MAX_TRACKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_cmd    (req_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .limit      (limit)
   );

   des_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   des_back #(
      .QUEUE_CAPACITY (QUEUE_CAPACITY),
      .UNIT_COUNT     (UNIT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_ready  (pop_ready),
      .in_cmd    (pop_cmd),
      .limit     (limit),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {2'b00, rsp.write, rsp.requester, rsp.buffer, rsp.sector,
                       rsp.track, rsp.unit};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

   // anything but a sector command is a single result
   `ASSERT_IMPLY(a_status_last, clock, reset,
      rsp_tvalid && (rsp_tuser != ST_CMD), rsp_tlast)
   // sector commands stay within the track
   `ASSERT_IMPLY(a_sector_range, clock, reset,
      rsp_tvalid && (rsp_tuser == ST_CMD),
      SUM_W'(rsp_tdata[14:11]) < SUM_W'(SECTORS_PER_TRACK))
   `ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_tvalid)

endmodule

`default_nettype wire
